>>> rtl/bts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the bilinear texture sampler.
// Used by every module of the block; depends on nothing.
package bts_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned WT_W      = 2 * FRAC_BITS + 1;
  localparam int unsigned PROD_W    = WT_W + CH_W;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef rgb_t [3:0] quad_t;

  typedef struct packed {
    logic                      oob;
    logic [3:0][WT_W-1:0]      wt;
  } samp_t;

endpackage

>>> rtl/bts_front.sv
`timescale 1ns / 1ps
// Input stage: decodes a transaction, computes row bases, columns and weights.
// Depends on bts_pkg.
module bts_front #(
  parameter int unsigned MAX_DIM = 256,
  parameter int unsigned AW      = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [bts_pkg::IDX_W-1:0]     texel_index_i,
  input  logic [bts_pkg::CH_W-1:0]      red_in_i,
  input  logic [bts_pkg::CH_W-1:0]      green_in_i,
  input  logic [bts_pkg::CH_W-1:0]      blue_in_i,
  input  logic [bts_pkg::COORD_W-1:0]   coord_x_i,
  input  logic [bts_pkg::COORD_W-1:0]   coord_y_i,
  input  logic [bts_pkg::DIM_W-1:0]     tex_width_i,
  input  logic [bts_pkg::DIM_W-1:0]     tex_height_i,
  output logic                          s1_valid_o,
  input  logic                          s1_ready_i,
  output bts_pkg::op_e                  s1_op_o,
  output logic                          s1_wr_en_o,
  output logic [AW-1:0]                 s1_wr_addr_o,
  output bts_pkg::rgb_t                 s1_wr_data_o,
  output logic [AW-1:0]                 s1_row0_o,
  output logic [AW-1:0]                 s1_row1_o,
  output logic [bts_pkg::DIM_W-1:0]     s1_col0_o,
  output logic [bts_pkg::DIM_W-1:0]     s1_col1_o,
  output bts_pkg::samp_t                s1_samp_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned DW = bts_pkg::DIM_W;
  localparam int unsigned FB = bts_pkg::FRAC_BITS;
  localparam int unsigned WW = bts_pkg::WT_W;

  logic          s1_valid_q, s1_valid_d;
  logic          take;
  logic [DW-1:0] w_c, h_c, ix, iy, ix1, iy1;
  logic [FB-1:0] fx, fy;
  logic [FB:0]   omx, omy;
  logic [AW-1:0] row0, row1;
  bts_pkg::samp_t samp;

  bts_pkg::op_e   op_q;
  logic           wr_en_q;
  logic [AW-1:0]  wr_addr_q, row0_q, row1_q;
  bts_pkg::rgb_t  wr_data_q;
  logic [DW-1:0]  col0_q, col1_q;
  bts_pkg::samp_t samp_q;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;

  always_comb begin
    w_c = tex_width_i;
    if (tex_width_i == '0) begin
      w_c = DW'(1);
    end else if (32'(tex_width_i) > MAX_DIM) begin
      w_c = DW'(MAX_DIM);
    end
    h_c = tex_height_i;
    if (tex_height_i == '0) begin
      h_c = DW'(1);
    end else if (32'(tex_height_i) > MAX_DIM) begin
      h_c = DW'(MAX_DIM);
    end
    ix  = DW'(coord_x_i[bts_pkg::COORD_W-1:FB]);
    iy  = DW'(coord_y_i[bts_pkg::COORD_W-1:FB]);
    fx  = coord_x_i[FB-1:0];
    fy  = coord_y_i[FB-1:0];
    omx = bts_pkg::ONE - (FB + 1)'(fx);
    omy = bts_pkg::ONE - (FB + 1)'(fy);
    ix1 = (ix + DW'(1) < w_c) ? ix + DW'(1) : w_c - DW'(1);
    iy1 = (iy + DW'(1) < h_c) ? iy + DW'(1) : h_c - DW'(1);
    row0 = AW'(iy) * AW'(w_c);
    row1 = AW'(iy1) * AW'(w_c);
    samp.oob   = (ix >= w_c) || (iy >= h_c);
    samp.wt[0] = WW'(omx) * WW'(omy);
    samp.wt[1] = WW'(fx) * WW'(omy);
    samp.wt[2] = WW'(omx) * WW'(fy);
    samp.wt[3] = WW'(fx) * WW'(fy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q      <= bts_pkg::op_e'(op_i);
      wr_en_q   <= 32'(texel_index_i) < DEPTH;
      wr_addr_q <= AW'(texel_index_i);
      wr_data_q <= '{red: red_in_i, green: green_in_i, blue: blue_in_i};
      row0_q    <= row0;
      row1_q    <= row1;
      col0_q    <= ix;
      col1_q    <= ix1;
      samp_q    <= samp;
    end
  end

  assign s1_valid_o   = s1_valid_q;
  assign s1_op_o      = op_q;
  assign s1_wr_en_o   = wr_en_q;
  assign s1_wr_addr_o = wr_addr_q;
  assign s1_wr_data_o = wr_data_q;
  assign s1_row0_o    = row0_q;
  assign s1_row1_o    = row1_q;
  assign s1_col0_o    = col0_q;
  assign s1_col1_o    = col1_q;
  assign s1_samp_o    = samp_q;

endmodule

>>> rtl/bts_texmem.sv
`timescale 1ns / 1ps
// Texel store: two copies of the texture, each read at two addresses per cycle.
// Depends on bts_pkg.
module bts_texmem #(
  parameter int unsigned MAX_DIM = 256,
  parameter int unsigned AW      = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s1_valid_i,
  output logic                       s1_ready_o,
  input  bts_pkg::op_e               s1_op_i,
  input  logic                       s1_wr_en_i,
  input  logic [AW-1:0]              s1_wr_addr_i,
  input  bts_pkg::rgb_t              s1_wr_data_i,
  input  logic [AW-1:0]              s1_row0_i,
  input  logic [AW-1:0]              s1_row1_i,
  input  logic [bts_pkg::DIM_W-1:0]  s1_col0_i,
  input  logic [bts_pkg::DIM_W-1:0]  s1_col1_i,
  input  bts_pkg::samp_t             s1_samp_i,
  output logic                       s2_valid_o,
  input  logic                       s2_ready_i,
  output bts_pkg::quad_t             s2_quad_o,
  output bts_pkg::samp_t             s2_samp_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;

  // Reads and writes both happen as a transaction leaves the input stage,
  // so they reach the store in arrival order.
  bts_pkg::rgb_t  mem_top_q [DEPTH];
  bts_pkg::rgb_t  mem_bot_q [DEPTH];

  logic           s2_valid_q, s2_valid_d;
  logic           s2_free, is_wr, wr_fire, rd_fire;
  logic [AW-1:0]  a0, a1, a2, a3;
  bts_pkg::quad_t quad_q;
  bts_pkg::samp_t samp_q;

  assign is_wr      = s1_op_i == bts_pkg::OP_WRITE;
  assign s2_free    = !s2_valid_q || s2_ready_i;
  assign s1_ready_o = is_wr || s2_free;
  assign wr_fire    = s1_valid_i && is_wr && s1_wr_en_i;
  assign rd_fire    = s1_valid_i && !is_wr && s2_free;
  assign s2_valid_d = s2_free ? (s1_valid_i && !is_wr) : s2_valid_q;

  assign a0 = s1_row0_i + AW'(s1_col0_i);
  assign a1 = s1_row0_i + AW'(s1_col1_i);
  assign a2 = s1_row1_i + AW'(s1_col0_i);
  assign a3 = s1_row1_i + AW'(s1_col1_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_top_q[s1_wr_addr_i] <= s1_wr_data_i;
      mem_bot_q[s1_wr_addr_i] <= s1_wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      quad_q[0] <= mem_top_q[a0];
      quad_q[1] <= mem_top_q[a1];
      quad_q[2] <= mem_bot_q[a2];
      quad_q[3] <= mem_bot_q[a3];
      samp_q    <= s1_samp_i;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_quad_o  = quad_q;
  assign s2_samp_o  = samp_q;

endmodule

>>> rtl/bts_filter.sv
`timescale 1ns / 1ps
// Filter stages: weighted products per channel, then sum and output register.
// Depends on bts_pkg.
module bts_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s2_valid_i,
  output logic                       s2_ready_o,
  input  bts_pkg::quad_t             s2_quad_i,
  input  bts_pkg::samp_t             s2_samp_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bts_pkg::OUT_W-1:0]  red_out_o,
  output logic [bts_pkg::OUT_W-1:0]  green_out_o,
  output logic [bts_pkg::OUT_W-1:0]  blue_out_o,
  output logic                       out_of_range_o
);

  localparam int unsigned PW = bts_pkg::PROD_W;
  localparam int unsigned SW = bts_pkg::SUM_W;
  localparam int unsigned FB = bts_pkg::FRAC_BITS;
  localparam int unsigned OW = bts_pkg::OUT_W;

  logic                           s3_valid_q, s3_valid_d, s3_ready;
  logic                           out_valid_q, out_valid_d;
  logic [3:0][2:0][bts_pkg::CH_W-1:0] chv;
  logic [2:0][3:0][PW-1:0]        prod_d, prod_q;
  logic                           s3_oob_q;
  logic [2:0][SW-1:0]             sum;
  logic [2:0][OW-1:0]             res_d, res_q;
  logic                           oob_q;

  assign s3_ready    = !out_valid_q || out_ready_i;
  assign s2_ready_o  = !s3_valid_q || s3_ready;
  assign s3_valid_d  = s2_ready_o ? s2_valid_i : s3_valid_q;
  assign out_valid_d = s3_ready ? s3_valid_q : out_valid_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      chv[k][0] = s2_quad_i[k].red;
      chv[k][1] = s2_quad_i[k].green;
      chv[k][2] = s2_quad_i[k].blue;
    end
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        prod_d[c][k] = PW'(s2_samp_i.wt[k]) * PW'(chv[k][c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = SW'(prod_q[c][0]) + SW'(prod_q[c][1])
             + SW'(prod_q[c][2]) + SW'(prod_q[c][3]);
      res_d[c] = s3_oob_q ? '0 : sum[c][FB+OW-1:FB];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s3_valid_q  <= s3_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_i && s2_ready_o) begin
      prod_q   <= prod_d;
      s3_oob_q <= s2_samp_i.oob;
    end
    if (s3_valid_q && s3_ready) begin
      res_q <= res_d;
      oob_q <= s3_oob_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_out_o      = res_q[0];
  assign green_out_o    = res_q[1];
  assign blue_out_o     = res_q[2];
  assign out_of_range_o = oob_q;

endmodule

>>> rtl/bilinear_texture_sampler.sv
`timescale 1ns / 1ps
// Top level of the bilinear texture sampler with its configuration registers.
// Depends on bts_pkg, bts_front, bts_texmem and bts_filter.
//
// The input channel carries two kinds of transaction. A write (op 0) stores
// one RGB texel at texel_index_i and produces no result. A sample (op 1)
// takes coord_x_i and coord_y_i with 8 fraction bits, reads the 2x2 texel
// quad and returns one result with each channel in 8.8 fixed point. Right
// and lower neighbors are clamped to the last column and row; a sample whose
// integer coordinate lies outside the texture returns zeros with
// out_of_range_o set. Texture width and height come from the APB registers
// at byte addresses 0 and 4. The user must write them only while the block
// is idle; the block does not enforce it. One transaction per cycle is
// accepted unless the receiver stalls, set by the two dual-read texel
// memories that fetch the whole quad in one access. A write is visible to
// every sample accepted after it. Reset clears the pipeline valids and sets
// both dimensions to 256; the texel store holds no defined value until
// written. When the receiver stalls, the four pipeline stages (input, texel,
// product, output) fill and in_ready_o drops only once all are occupied.
module bilinear_texture_sampler #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [bts_pkg::IDX_W-1:0]     texel_index_i,
  input  logic [bts_pkg::CH_W-1:0]      red_in_i,
  input  logic [bts_pkg::CH_W-1:0]      green_in_i,
  input  logic [bts_pkg::CH_W-1:0]      blue_in_i,
  input  logic [bts_pkg::COORD_W-1:0]   coord_x_i,
  input  logic [bts_pkg::COORD_W-1:0]   coord_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bts_pkg::OUT_W-1:0]     red_out_o,
  output logic [bts_pkg::OUT_W-1:0]     green_out_o,
  output logic [bts_pkg::OUT_W-1:0]     blue_out_o,
  output logic                          out_of_range_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bts_pkg::APB_AW-1:0]    paddr,
  input  logic [bts_pkg::APB_DW-1:0]    pwdata,
  output logic [bts_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned DW = bts_pkg::DIM_W;

  logic [DW-1:0]      tex_width_q, tex_width_d, tex_height_q, tex_height_d;
  logic               cfg_wr;
  bts_pkg::reg_idx_e  reg_idx;

  logic               s1_valid, s1_ready, s1_wr_en;
  bts_pkg::op_e       s1_op;
  logic [AW-1:0]      s1_wr_addr, s1_row0, s1_row1;
  bts_pkg::rgb_t      s1_wr_data;
  logic [DW-1:0]      s1_col0, s1_col1;
  bts_pkg::samp_t     s1_samp, s2_samp;
  logic               s2_valid, s2_ready;
  bts_pkg::quad_t     s2_quad;

  assign pready  = 1'b1;
  assign reg_idx = bts_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    tex_width_d  = tex_width_q;
    tex_height_d = tex_height_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        bts_pkg::REG_TEX_WIDTH:  tex_width_d  = pwdata[DW-1:0];
        bts_pkg::REG_TEX_HEIGHT: tex_height_d = pwdata[DW-1:0];
        default:                 tex_width_d  = tex_width_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bts_pkg::REG_TEX_WIDTH:  prdata = bts_pkg::APB_DW'(tex_width_q);
      bts_pkg::REG_TEX_HEIGHT: prdata = bts_pkg::APB_DW'(tex_height_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= bts_pkg::DIM_RESET;
      tex_height_q <= bts_pkg::DIM_RESET;
    end else begin
      tex_width_q  <= tex_width_d;
      tex_height_q <= tex_height_d;
    end
  end

  bts_front #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .texel_index_i (texel_index_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .tex_width_i   (tex_width_q),
    .tex_height_i  (tex_height_q),
    .s1_valid_o    (s1_valid),
    .s1_ready_i    (s1_ready),
    .s1_op_o       (s1_op),
    .s1_wr_en_o    (s1_wr_en),
    .s1_wr_addr_o  (s1_wr_addr),
    .s1_wr_data_o  (s1_wr_data),
    .s1_row0_o     (s1_row0),
    .s1_row1_o     (s1_row1),
    .s1_col0_o     (s1_col0),
    .s1_col1_o     (s1_col1),
    .s1_samp_o     (s1_samp)
  );

  bts_texmem #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_texmem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid),
    .s1_ready_o   (s1_ready),
    .s1_op_i      (s1_op),
    .s1_wr_en_i   (s1_wr_en),
    .s1_wr_addr_i (s1_wr_addr),
    .s1_wr_data_i (s1_wr_data),
    .s1_row0_i    (s1_row0),
    .s1_row1_i    (s1_row1),
    .s1_col0_i    (s1_col0),
    .s1_col1_i    (s1_col1),
    .s1_samp_i    (s1_samp),
    .s2_valid_o   (s2_valid),
    .s2_ready_i   (s2_ready),
    .s2_quad_o    (s2_quad),
    .s2_samp_o    (s2_samp)
  );

  bts_filter u_filter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s2_valid_i     (s2_valid),
    .s2_ready_o     (s2_ready),
    .s2_quad_i      (s2_quad),
    .s2_samp_i      (s2_samp),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

>>> rtl/bts_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the bilinear texture sampler and their bind statement.
// Depends on bts_pkg and the top level bilinear_texture_sampler.
module bts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [bts_pkg::OUT_W-1:0]     red_out_o,
  input logic [bts_pkg::OUT_W-1:0]     green_out_o,
  input logic [bts_pkg::OUT_W-1:0]     blue_out_o,
  input logic                          out_of_range_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [bts_pkg::APB_AW-1:0]    paddr,
  input logic [bts_pkg::APB_DW-1:0]    pwdata,
  input logic [bts_pkg::APB_DW-1:0]    prdata
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o)
      && $stable(green_out_o) && $stable(blue_out_o) && $stable(out_of_range_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |->
      red_out_o == '0 && green_out_o == '0 && blue_out_o == '0)
    else $error("out-of-range sample returned nonzero color");

  // A weighted mean of 8-bit texels cannot exceed 255.0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> red_out_o <= 16'hFF00 && green_out_o <= 16'hFF00
      && blue_out_o <= 16'hFF00)
    else $error("filtered channel above full scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) ##1 (psel && !pwrite && paddr[2] == $past(paddr[2])) |->
      prdata[8:0] == $past(pwdata[8:0]) && prdata[31:9] == '0)
    else $error("register readback differs from last write");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (.*);

>>> tb/bilinear_texture_sampler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bilinear texture sampler: directed rows, then random phases.
// Depends on bts_pkg and bilinear_texture_sampler; predicts samples without a typed result.
module bilinear_texture_sampler_tb;

  localparam int unsigned FRAC_BITS      = bts_pkg::FRAC_BITS;
  localparam int unsigned OUT_W          = bts_pkg::OUT_W;
  localparam int unsigned IDX_W          = bts_pkg::IDX_W;
  localparam int unsigned COORD_W        = bts_pkg::COORD_W;
  localparam int unsigned DIM_W          = bts_pkg::DIM_W;
  localparam int unsigned CH_W           = bts_pkg::CH_W;
  localparam int unsigned APB_AW         = bts_pkg::APB_AW;
  localparam int unsigned APB_DW         = bts_pkg::APB_DW;
  localparam int unsigned MAX_DIM        = 256;
  localparam int unsigned UNIT           = 1 << FRAC_BITS;
  localparam int unsigned STORE_DEPTH    = MAX_DIM * MAX_DIM;
  localparam int unsigned IDLE_SETTLE    = 8;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned NUM_DIRECTED   = 26;
  localparam int unsigned PRINT_CAP      = 50;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
    logic             oob;
  } filtered_t;

  typedef logic [3:0][IDX_W-1:0] quad_addr_t;

  typedef enum logic {
    ROW_TRANSACTION,
    ROW_DIMENSIONS
  } row_kind_e;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct {
    row_kind_e            kind;
    bts_pkg::op_e         op;
    logic [IDX_W-1:0]     index;
    bts_pkg::rgb_t        color;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   cy;
    bit                   typed;
    filtered_t            want;
    logic [DIM_W-1:0]     width;
    logic [DIM_W-1:0]     height;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 op_i;
  logic [IDX_W-1:0]     texel_index_i;
  logic [CH_W-1:0]      red_in_i;
  logic [CH_W-1:0]      green_in_i;
  logic [CH_W-1:0]      blue_in_i;
  logic [COORD_W-1:0]   coord_x_i;
  logic [COORD_W-1:0]   coord_y_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [OUT_W-1:0]     red_out_o;
  logic [OUT_W-1:0]     green_out_o;
  logic [OUT_W-1:0]     blue_out_o;
  logic                 out_of_range_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  bts_pkg::rgb_t        texel_model [0:STORE_DEPTH-1];
  bit                   written_map [0:STORE_DEPTH-1];
  filtered_t            pending_filtered [$];
  logic [DIM_W-1:0]     dim_width;
  logic [DIM_W-1:0]     dim_height;
  int unsigned          gen_width;
  int unsigned          gen_height;
  bit                   typed_valid;
  filtered_t            typed_value;
  int unsigned          burst_left;
  int unsigned          mismatch_count;
  int unsigned          stall_cycles;
  row_t                 directed_rows [NUM_DIRECTED];

  bilinear_texture_sampler #(
    .MAX_DIM(MAX_DIM)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .texel_index_i  (texel_index_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .out_of_range_o (out_of_range_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned dim_used(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic quad_addr_t texel_quad(int unsigned ix, int unsigned iy,
                                            int unsigned w, int unsigned h);
    int unsigned ix1;
    int unsigned iy1;
    ix1 = (ix + 1 < w) ? ix + 1 : w - 1;
    iy1 = (iy + 1 < h) ? iy + 1 : h - 1;
    return {IDX_W'(iy1 * w + ix1), IDX_W'(iy1 * w + ix),
            IDX_W'(iy * w + ix1), IDX_W'(iy * w + ix)};
  endfunction

  function automatic logic [OUT_W-1:0] saturate_channel(int unsigned acc);
    return (acc > 32'hFFFF) ? 16'hFFFF : OUT_W'(acc);
  endfunction

  function automatic filtered_t filter_sample(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    int unsigned   w, h, ix, iy, fx, fy;
    int unsigned   acc_r, acc_g, acc_b;
    int unsigned   wt [4];
    quad_addr_t    q;
    bts_pkg::rgb_t t;
    filtered_t     res;
    w = dim_used(dim_width);
    h = dim_used(dim_height);
    ix = int'(cx) >> FRAC_BITS;
    iy = int'(cy) >> FRAC_BITS;
    fx = int'(cx) & (UNIT - 1);
    fy = int'(cy) & (UNIT - 1);
    res = '0;
    if (ix >= w || iy >= h) begin
      res.oob = 1'b1;
      return res;
    end
    q = texel_quad(ix, iy, w, h);
    wt[0] = (UNIT - fx) * (UNIT - fy);
    wt[1] = fx * (UNIT - fy);
    wt[2] = (UNIT - fx) * fy;
    wt[3] = fx * fy;
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    for (int k = 0; k < 4; k++) begin
      t = texel_model[q[k]];
      acc_r += wt[k] * t.red;
      acc_g += wt[k] * t.green;
      acc_b += wt[k] * t.blue;
    end
    res.red   = saturate_channel(acc_r >> FRAC_BITS);
    res.green = saturate_channel(acc_g >> FRAC_BITS);
    res.blue  = saturate_channel(acc_b >> FRAC_BITS);
    return res;
  endfunction

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic bts_pkg::rgb_t rand_color();
    return {rand_channel(), rand_channel(), rand_channel()};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_CAP) begin
      $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $realtime);
    end
    mismatch_count++;
  endtask

  task automatic send_item(bts_pkg::op_e op, logic [IDX_W-1:0] index, bts_pkg::rgb_t color,
                           logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                           bit typed, filtered_t want);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op;
    if (op == bts_pkg::OP_WRITE) begin
      texel_index_i = index;
      {red_in_i, green_in_i, blue_in_i} = color;
      coord_x_i = COORD_W'($urandom);
      coord_y_i = COORD_W'($urandom);
      written_map[index] = 1'b1;
    end else begin
      texel_index_i = IDX_W'($urandom);
      {red_in_i, green_in_i, blue_in_i} = rand_color();
      coord_x_i = cx;
      coord_y_i = cy;
    end
    typed_valid = typed;
    typed_value = want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic config_register(bts_pkg::reg_idx_e idx, logic [DIM_W-1:0] value);
    logic [APB_DW-1:0] readback;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_AW'({idx, 2'b00});
    pwdata  = ($urandom << DIM_W) | APB_DW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback[DIM_W-1:0] !== value) begin
      report_mismatch("register readback", readback, APB_DW'(value));
    end
  endtask

  task automatic apply_dimensions(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    wait_idle();
    config_register(bts_pkg::REG_TEX_WIDTH, w);
    config_register(bts_pkg::REG_TEX_HEIGHT, h);
    gen_width  = dim_used(w);
    gen_height = dim_used(h);
  endtask

  function automatic logic [CH_W-1:0] rand_frac();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  task automatic run_random_phase(logic [DIM_W-1:0] w_raw, logic [DIM_W-1:0] h_raw,
                                  int unsigned count);
    int unsigned sent, pick, ix, iy;
    quad_addr_t  q;
    logic [IDX_W-1:0] index;
    apply_dimensions(w_raw, h_raw);
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        ix = $urandom_range(0, gen_width - 1);
        iy = $urandom_range(0, gen_height - 1);
        q = texel_quad(ix, iy, gen_width, gen_height);
        for (int k = 0; k < 4; k++) begin
          if (!written_map[q[k]]) begin
            send_item(bts_pkg::OP_WRITE, q[k], rand_color(), '0, '0, 1'b0, '0);
            sent++;
          end
        end
        send_item(bts_pkg::OP_SAMPLE, '0, '0, {8'(ix), rand_frac()}, {8'(iy), rand_frac()},
                  1'b0, '0);
        sent++;
      end else if (pick < 82 && (gen_width < MAX_DIM || gen_height < MAX_DIM)) begin
        if (gen_width < MAX_DIM && (gen_height == MAX_DIM || $urandom_range(0, 1) == 1)) begin
          ix = $urandom_range(gen_width, MAX_DIM - 1);
          iy = $urandom_range(0, MAX_DIM - 1);
        end else begin
          ix = $urandom_range(0, MAX_DIM - 1);
          iy = $urandom_range(gen_height, MAX_DIM - 1);
        end
        send_item(bts_pkg::OP_SAMPLE, '0, '0, {8'(ix), rand_frac()}, {8'(iy), rand_frac()},
                  1'b0, '0);
        sent++;
      end else begin
        if (pick % 2 == 0) begin
          index = IDX_W'($urandom_range(0, gen_width * gen_height - 1));
        end else begin
          index = IDX_W'($urandom);
        end
        send_item(bts_pkg::OP_WRITE, index, rand_color(), '0, '0, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    filtered_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_filtered.size() == 0) begin
          report_mismatch("result with no sample pending", {red_out_o, green_out_o}, '0);
        end else begin
          want = pending_filtered.pop_front();
          if (red_out_o !== want.red) report_mismatch("red_out", red_out_o, want.red);
          if (green_out_o !== want.green) report_mismatch("green_out", green_out_o, want.green);
          if (blue_out_o !== want.blue) report_mismatch("blue_out", blue_out_o, want.blue);
          if (out_of_range_o !== want.oob) begin
            report_mismatch("out_of_range", out_of_range_o, want.oob);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (op_i == bts_pkg::OP_WRITE) begin
          texel_model[texel_index_i] = {red_in_i, green_in_i, blue_in_i};
        end else begin
          pending_filtered.push_back(typed_valid ? typed_value
                                                 : filter_sample(coord_x_i, coord_y_i));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (bts_pkg::reg_idx_e'(paddr[2]))
          bts_pkg::REG_TEX_WIDTH:  dim_width = pwdata[DIM_W-1:0];
          bts_pkg::REG_TEX_HEIGHT: dim_height = pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  initial begin
    stall_mode_e mode;
    int unsigned span, period, low_len;
    out_ready_i = 1'b1;
    forever begin
      mode    = stall_mode_e'($urandom_range(0, 2));
      span    = $urandom_range(40, 300);
      period  = $urandom_range(2, 8);
      low_len = $urandom_range(1, period - 1);
      for (int i = 0; i < span; i++) begin
        @(negedge clk_i);
        case (mode)
          STALL_NONE:     out_ready_i = 1'b1;
          STALL_RANDOM:   out_ready_i = 1'($urandom_range(0, 1));
          STALL_PERIODIC: out_ready_i = (i % period) >= low_len;
          default:        out_ready_i = 1'b1;
        endcase
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("FAIL bilinear_texture_sampler");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = bts_pkg::OP_WRITE;
    texel_index_i  = '0;
    red_in_i       = '0;
    green_in_i     = '0;
    blue_in_i      = '0;
    coord_x_i      = '0;
    coord_y_i      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    dim_width      = bts_pkg::DIM_RESET;
    dim_height     = bts_pkg::DIM_RESET;
    gen_width      = MAX_DIM;
    gen_height     = MAX_DIM;
    typed_valid    = 1'b0;
    typed_value    = '0;
    burst_left     = 0;
    mismatch_count = 0;

    directed_rows = '{
      '{ROW_TRANSACTION, bts_pkg::OP_WRITE, 16'd0, 24'hFFFFFF, 16'h0, 16'h0,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_WRITE, 16'd1, 24'hFFFFFF, 16'h0, 16'h0,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_WRITE, 16'd256, 24'hFFFFFF, 16'h0, 16'h0,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_WRITE, 16'd257, 24'hFFFFFF, 16'h0, 16'h0,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'h0080, 16'h0080, 1'b1,
        {16'hFF00, 16'hFF00, 16'hFF00, 1'b0}, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'h00FF, 16'h00FF, 1'b1,
        {16'hFF00, 16'hFF00, 16'hFF00, 1'b0}, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_WRITE, 16'd65535, 24'h123456, 16'h0, 16'h0,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'hFFFF, 16'hFFFF, 1'b1,
        {16'h1200, 16'h3400, 16'h5600, 1'b0}, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_WRITE, 16'd0, 24'hAA5500, 16'h0, 16'h0,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'h0040, 16'h00C0,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'h0000, 16'h0000, 1'b1,
        {16'hAA00, 16'h5500, 16'h0000, 1'b0}, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_WRITE, 16'd65280, 24'h0180FE, 16'h0, 16'h0,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_WRITE, 16'd65281, 24'h7F00FF, 16'h0, 16'h0,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'h0080, 16'hFF80,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_DIMENSIONS, bts_pkg::OP_WRITE, 16'd0, 24'h0, 16'h0, 16'h0,
        1'b0, '0, 9'd2, 9'd2},
      '{ROW_TRANSACTION, bts_pkg::OP_WRITE, 16'd2, 24'h102030, 16'h0, 16'h0,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_WRITE, 16'd3, 24'h405060, 16'h0, 16'h0,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'h0180, 16'h0180, 1'b1,
        {16'h4000, 16'h5000, 16'h6000, 1'b0}, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'h0200, 16'h0000, 1'b1,
        {16'h0, 16'h0, 16'h0, 1'b1}, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'h0000, 16'h0200, 1'b1,
        {16'h0, 16'h0, 16'h0, 1'b1}, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'h0080, 16'h0080,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_DIMENSIONS, bts_pkg::OP_WRITE, 16'd0, 24'h0, 16'h0, 16'h0,
        1'b0, '0, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'h00FF, 16'h00FF, 1'b1,
        {16'hAA00, 16'h5500, 16'h0000, 1'b0}, 9'd0, 9'd0},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'h0100, 16'h0000, 1'b1,
        {16'h0, 16'h0, 16'h0, 1'b1}, 9'd0, 9'd0},
      '{ROW_DIMENSIONS, bts_pkg::OP_WRITE, 16'd0, 24'h0, 16'h0, 16'h0,
        1'b0, '0, 9'd511, 9'd300},
      '{ROW_TRANSACTION, bts_pkg::OP_SAMPLE, 16'd0, 24'h0, 16'hFF00, 16'hFF00, 1'b1,
        {16'h1200, 16'h3400, 16'h5600, 1'b0}, 9'd0, 9'd0}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_DIMENSIONS) begin
        apply_dimensions(directed_rows[i].width, directed_rows[i].height);
      end else begin
        send_item(directed_rows[i].op, directed_rows[i].index, directed_rows[i].color,
                  directed_rows[i].cx, directed_rows[i].cy,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    run_random_phase(9'd256, 9'd256, PHASE_ITEMS);
    run_random_phase(9'd1, 9'd1, PHASE_ITEMS);
    run_random_phase(9'd0, 9'd0, PHASE_ITEMS);
    run_random_phase(9'd511, 9'd511, PHASE_ITEMS);
    run_random_phase(9'd1, 9'd256, PHASE_ITEMS);
    run_random_phase(9'd256, 9'd1, PHASE_ITEMS);
    run_random_phase(9'd300, 9'd2, PHASE_ITEMS);
    run_random_phase(9'd3, 9'd7, PHASE_ITEMS);
    for (int p = 0; p < 5; p++) begin
      if ($urandom_range(0, 4) == 0) begin
        run_random_phase(DIM_W'($urandom), DIM_W'($urandom), PHASE_ITEMS);
      end else begin
        run_random_phase(DIM_W'($urandom_range(1, 64)), DIM_W'($urandom_range(1, 64)),
                         PHASE_ITEMS);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS bilinear_texture_sampler");
    end else begin
      $display("FAIL bilinear_texture_sampler");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bts_pkg.sv
rtl/bts_front.sv
rtl/bts_texmem.sv
rtl/bts_filter.sv
rtl/bilinear_texture_sampler.sv
rtl/bts_checker.sv
tb/bilinear_texture_sampler_tb.sv
